// File: rtl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the center pad/crop block
// Field structs for both channels, config and derived geometry, queue entry.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SIZE_W      = 13;   // size register width
    localparam int COORD_W     = 12;   // source column/row counters
    localparam int POS_W       = 14;   // signed mapped position
    localparam int IDX_W       = 25;   // output raster index / run length
    localparam int COLOR_W     = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // register indexes on the config port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_WIDTH  = 3'd0,
        REG_TARGET_HEIGHT = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_BG_RED        = 3'd4,
        REG_BG_GREEN      = 3'd5,
        REG_BG_BLUE       = 3'd6
    } cfg_reg_t;

    // result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic               item_kind;
        logic [IDX_W-1:0]   run_length;
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic               frame_end;
    } result_t;

    // sizes are held already clamped to 1..MAX
    typedef struct packed {
        logic [SIZE_W-1:0]  target_width;
        logic [SIZE_W-1:0]  target_height;
        logic [SIZE_W-1:0]  source_width;
        logic [SIZE_W-1:0]  source_height;
        logic [COLOR_W-1:0] bg_red;
        logic [COLOR_W-1:0] bg_green;
        logic [COLOR_W-1:0] bg_blue;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic [SIZE_W-1:0]       end_x;
        logic [SIZE_W-1:0]       end_y;
        logic [IDX_W-1:0]        total;
        logic [IDX_W-1:0]        total_m1;
    } geom_t;

    // one queued command: up to three results for one source pixel
    typedef struct packed {
        logic               gap_en;
        logic               pix_en;
        logic               tail_en;
        logic [IDX_W-1:0]   gap_len;
        logic [IDX_W-1:0]   tail_len;
        pixel_t             pixel;
        logic               pix_fe;
    } cmd_t;

endpackage

// File: rtl/cpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_cfg: configuration registers and derived frame geometry
// Sizes are clamped on write; offsets, limits and pixel total are registered.
// ----------------------------------------------------------------------------
module cpc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpc_pkg::SIZE_W-1:0]    cfg_wdata,
    output cpc_pkg::cfg_t                 cfg,
    output cpc_pkg::geom_t                geom
);
    import cpc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    geom_t geom_reg, geom_next;

    logic [SIZE_W-1:0] w_clamp, h_clamp;
    logic signed [POS_W-1:0] dx, dy;
    logic [SIZE_W:0] sum_x, sum_y;

    // clamp a written size to 1..MAX
    always_comb begin
        if (cfg_wdata == '0) begin
            w_clamp = SIZE_W'(1);
        end else if (cfg_wdata > SIZE_W'(MAX_WIDTH)) begin
            w_clamp = SIZE_W'(MAX_WIDTH);
        end else begin
            w_clamp = cfg_wdata;
        end
        if (cfg_wdata == '0) begin
            h_clamp = SIZE_W'(1);
        end else if (cfg_wdata > SIZE_W'(MAX_HEIGHT)) begin
            h_clamp = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_clamp = cfg_wdata;
        end
    end

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TARGET_WIDTH:  cfg_next.target_width  = w_clamp;
                REG_TARGET_HEIGHT: cfg_next.target_height = h_clamp;
                REG_SOURCE_WIDTH:  cfg_next.source_width  = w_clamp;
                REG_SOURCE_HEIGHT: cfg_next.source_height = h_clamp;
                REG_BG_RED:        cfg_next.bg_red   = cfg_wdata[COLOR_W-1:0];
                REG_BG_GREEN:      cfg_next.bg_green = cfg_wdata[COLOR_W-1:0];
                REG_BG_BLUE:       cfg_next.bg_blue  = cfg_wdata[COLOR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // start = (T-S)/2 toward zero, end = (T+S)/2, total = Tw*Th
    always_comb begin
        dx = $signed({1'b0, cfg_reg.target_width}) - $signed({1'b0, cfg_reg.source_width});
        dy = $signed({1'b0, cfg_reg.target_height}) - $signed({1'b0, cfg_reg.source_height});
        sum_x = {1'b0, cfg_reg.target_width} + {1'b0, cfg_reg.source_width};
        sum_y = {1'b0, cfg_reg.target_height} + {1'b0, cfg_reg.source_height};
        geom_next.start_x  = (dx + $signed({{(POS_W-1){1'b0}}, dx[POS_W-1]})) >>> 1;
        geom_next.start_y  = (dy + $signed({{(POS_W-1){1'b0}}, dy[POS_W-1]})) >>> 1;
        geom_next.end_x    = sum_x[SIZE_W:1];
        geom_next.end_y    = sum_y[SIZE_W:1];
        geom_next.total    = IDX_W'(cfg_reg.target_width) * IDX_W'(cfg_reg.target_height);
        geom_next.total_m1 = geom_next.total - IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_width  <= SIZE_W'(1);
            cfg_reg.target_height <= SIZE_W'(1);
            cfg_reg.source_width  <= SIZE_W'(1);
            cfg_reg.source_height <= SIZE_W'(1);
            cfg_reg.bg_red        <= '0;
            cfg_reg.bg_green      <= '0;
            cfg_reg.bg_blue       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    assign cfg  = cfg_reg;
    assign geom = geom_reg;

endmodule

// File: rtl/cpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_front: source position tracking and pixel classification
// Four register stages map each source pixel to an output index and turn it
// into a command of gap run, image pixel and tail run for the back end.
// ----------------------------------------------------------------------------
module cpc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  cpc_pkg::cfg_t  cfg,
    input  cpc_pkg::geom_t geom,
    input  logic           s_valid,
    output logic           s_ready,
    input  cpc_pkg::pixel_t s_data,
    input  logic           q_full,
    output logic           q_push,
    output cpc_pkg::cmd_t  q_cmd
);
    import cpc_pkg::*;

    logic adv;
    logic accept;

    // source position counters
    logic [COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic last_col, last_row;

    // stage 1: position and pixel
    logic               v1_reg;
    logic [COORD_W-1:0] c1_reg, r1_reg;
    pixel_t             p1_reg;
    logic               last1_reg;

    // stage 2: keep decision and row product
    logic               v2_reg, keep2_reg, last2_reg;
    logic [COORD_W-1:0] x2_reg;
    logic [IDX_W-1:0]   prod2_reg;
    pixel_t             p2_reg;
    logic signed [POS_W-1:0] x_pos, y_pos;
    logic keep_c;

    // stage 3: output index
    logic               v3_reg, keep3_reg, last3_reg;
    logic [IDX_W-1:0]   idx3_reg;
    pixel_t             p3_reg;

    // stage 4: index-only results
    logic               v4_reg, keep4_reg, last4_reg, fe4_reg, tailk_en4_reg;
    logic [IDX_W-1:0]   idx4_reg, idx_p1_4_reg, tailk_len4_reg;
    pixel_t             p4_reg;

    // next output index
    logic [IDX_W-1:0]   noi_reg, noi_next;
    cmd_t               cmd_c;

    // whole pipeline moves together while the queue has room
    assign adv     = !q_full;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // raster counters, compared against the clamped source size
    always_comb begin
        last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= cfg.source_width;
        last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= cfg.source_height;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_W'(1);
            end else begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    // mapped position and window test
    always_comb begin
        x_pos = $signed({2'b00, c1_reg}) + geom.start_x;
        y_pos = $signed({2'b00, r1_reg}) + geom.start_y;
        keep_c = (x_pos >= 0) && (x_pos < $signed({1'b0, cfg.target_width}))
              && (x_pos < $signed({1'b0, geom.end_x}))
              && (y_pos >= 0) && (y_pos < $signed({1'b0, cfg.target_height}))
              && (y_pos < $signed({1'b0, geom.end_y}));
    end

    // command build against the running output index
    always_comb begin
        cmd_c.gap_en   = 1'b0;
        cmd_c.gap_len  = idx4_reg - noi_reg;
        cmd_c.pix_en   = keep4_reg;
        cmd_c.pixel    = p4_reg;
        cmd_c.pix_fe   = fe4_reg;
        cmd_c.tail_en  = 1'b0;
        cmd_c.tail_len = tailk_len4_reg;
        noi_next       = noi_reg;
        if (keep4_reg) begin
            cmd_c.gap_en  = idx4_reg > noi_reg;
            cmd_c.tail_en = last4_reg && tailk_en4_reg;
            noi_next      = idx_p1_4_reg;
        end else begin
            cmd_c.tail_en  = last4_reg && (geom.total > noi_reg);
            cmd_c.tail_len = geom.total - noi_reg;
        end
        if (last4_reg) begin
            noi_next = '0;
        end
    end

    assign q_push = adv && v4_reg && (cmd_c.gap_en || cmd_c.pix_en || cmd_c.tail_en);
    assign q_cmd  = cmd_c;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            noi_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv) begin
                v1_reg <= accept;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                if (v4_reg) begin
                    noi_reg <= noi_next;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg    <= col_reg;
            r1_reg    <= row_reg;
            p1_reg    <= s_data;
            last1_reg <= last_col && last_row;

            keep2_reg <= keep_c;
            last2_reg <= last1_reg;
            x2_reg    <= x_pos[COORD_W-1:0];
            prod2_reg <= IDX_W'(y_pos[COORD_W-1:0]) * IDX_W'(cfg.target_width);
            p2_reg    <= p1_reg;

            keep3_reg <= keep2_reg;
            last3_reg <= last2_reg;
            idx3_reg  <= prod2_reg + IDX_W'(x2_reg);
            p3_reg    <= p2_reg;

            keep4_reg      <= keep3_reg;
            last4_reg      <= last3_reg;
            idx4_reg       <= idx3_reg;
            idx_p1_4_reg   <= idx3_reg + IDX_W'(1);
            fe4_reg        <= idx3_reg == geom.total_m1;
            tailk_en4_reg  <= idx3_reg < geom.total_m1;
            tailk_len4_reg <= geom.total_m1 - idx3_reg;
            p4_reg         <= p3_reg;
        end
    end

endmodule

// File: rtl/cpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_queue: short command queue between front and back ends
// Four entries, first-word fall-through read.
// ----------------------------------------------------------------------------
module cpc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cpc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          q_valid,
    output logic          q_full,
    output cpc_pkg::cmd_t q_cmd
);
    import cpc_pkg::*;

    cmd_t               mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    assign do_pop  = pop && (count_reg != '0);
    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == Q_CNT_W'(QUEUE_DEPTH);
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/cpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_back: command expansion into result items
// Emits gap run, image pixel and tail run in that order, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cpc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  cpc_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  cpc_pkg::cmd_t   q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output cpc_pkg::result_t m_data
);
    import cpc_pkg::*;

    cmd_t     cur_reg;
    logic [2:0] pend_reg, pend_next, sel, pend_after;  // {tail, pix, gap}
    logic     slot_free, emit;
    logic     m_valid_reg, m_valid_next;
    result_t  m_data_reg, m_data_next;

    // lowest pending result goes first
    always_comb begin
        sel = pend_reg & (~pend_reg + 3'd1);
        slot_free = !m_valid_reg || m_ready;
        emit = slot_free && (pend_reg != 3'b000);
        pend_after = emit ? (pend_reg & ~sel) : pend_reg;
        q_pop = q_valid && (pend_after == 3'b000);
        pend_next = q_pop ? {q_cmd.tail_en, q_cmd.pix_en, q_cmd.gap_en} : pend_after;
    end

    // result mux
    always_comb begin
        m_data_next.item_kind  = KIND_RUN;
        m_data_next.run_length = cur_reg.gap_len;
        m_data_next.out_red    = cfg.bg_red;
        m_data_next.out_green  = cfg.bg_green;
        m_data_next.out_blue   = cfg.bg_blue;
        m_data_next.frame_end  = 1'b0;
        if (sel[1]) begin
            m_data_next.item_kind  = KIND_PIXEL;
            m_data_next.run_length = IDX_W'(1);
            m_data_next.out_red    = cur_reg.pixel.pixel_red;
            m_data_next.out_green  = cur_reg.pixel.pixel_green;
            m_data_next.out_blue   = cur_reg.pixel.pixel_blue;
            m_data_next.frame_end  = cur_reg.pix_fe;
        end else if (sel[2]) begin
            m_data_next.run_length = cur_reg.tail_len;
            m_data_next.frame_end  = 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/center_pad_crop_image.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_pad_crop_image: centered pad/crop of an RGB raster stream
// Source pixels in, target frame out as image pixels and background runs.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock while the command queue has
// room and emits up to three results for it (gap run, image pixel, tail run
// at end of frame), one result per clock while the output is not stalled,
// from a registered output. A pixel that is cropped and is not the last of
// the frame makes no result. The pixel enters the first of four front
// stages (position, window test and row multiply, index add, index
// compares) when it is taken, and the three further front stages, the
// queue write, the expansion stage and the output register follow. A
// four-entry command queue sits between front and back end, so a stalled
// output does not stop the front until it fills.
// Config writes are taken at once into the size and color registers, with
// the derived geometry registered from those; write them only while no
// frame is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module center_pad_crop_image (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpc_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cpc_pkg::pixel_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cpc_pkg::result_t               m_data
);
    import cpc_pkg::*;

    cfg_t  cfg;
    geom_t geom;
    logic  q_full, q_push, q_pop, q_valid;
    cmd_t  push_cmd, q_cmd;

    cpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .geom      (geom)
    );

    cpc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .geom    (geom),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    cpc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    cpc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/cpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_checker: port-level checks for the center pad/crop block
// Result framing and output handshake behavior, bound to the top level.
// ----------------------------------------------------------------------------
module cpc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input cpc_pkg::result_t m_data
);
    import cpc_pkg::*;

    // a stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an image pixel covers exactly one output pixel
    a_pix_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.item_kind == KIND_PIXEL) |-> m_data.run_length == IDX_W'(1))
        else $error("image pixel with run length other than one");

    // a background run is never empty
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.item_kind == KIND_RUN) |-> m_data.run_length != '0)
        else $error("empty background run");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind center_pad_crop_image cpc_checker u_cpc_checker (.*);

// File: tb/sv/cpc_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_sb_pkg: result predictor and checker for center_pad_crop_image
// Keeps its own copy of the size/color registers and the raster position,
// works out the gap run, image pixel and tail run for each source pixel
// taken, and compares each output result with the oldest one pending.
// ----------------------------------------------------------------------------
package cpc_sb_pkg;

    import cpc_pkg::*;

    class pad_crop_scoreboard;

        // register copies, raw as written
        logic [SIZE_W-1:0]  tgt_w, tgt_h, src_w, src_h;
        logic [COLOR_W-1:0] bg_r, bg_g, bg_b;

        // raster position of the next source pixel, next output index
        logic [COORD_W-1:0] col, row;
        logic [IDX_W-1:0]   next_idx;

        result_t pending_results[$];
        int      errors;

        function new();
            tgt_w = SIZE_W'(1); tgt_h = SIZE_W'(1);
            src_w = SIZE_W'(1); src_h = SIZE_W'(1);
            bg_r = '0; bg_g = '0; bg_b = '0;
            col = '0; row = '0; next_idx = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [SIZE_W-1:0] val);
            case (idx)
                REG_TARGET_WIDTH:  tgt_w = val;
                REG_TARGET_HEIGHT: tgt_h = val;
                REG_SOURCE_WIDTH:  src_w = val;
                REG_SOURCE_HEIGHT: src_h = val;
                REG_BG_RED:        bg_r = val[COLOR_W-1:0];
                REG_BG_GREEN:      bg_g = val[COLOR_W-1:0];
                REG_BG_BLUE:       bg_b = val[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // zero reads as one, oversize reads as the maximum
        function int eff_size(logic [SIZE_W-1:0] v, int max_v);
            if (v == 0) return 1;
            if (v > max_v) return max_v;
            return int'(v);
        endfunction

        function void push_run(int unsigned len, logic fe);
            result_t r;
            r.item_kind  = KIND_RUN;
            r.run_length = IDX_W'(len);
            r.out_red    = bg_r;
            r.out_green  = bg_g;
            r.out_blue   = bg_b;
            r.frame_end  = fe;
            pending_results.push_back(r);
        endfunction

        function void note_source_pixel(pixel_t p);
            int          tw, th, sw, sh, sx, sy, ex, ey, x, y;
            int unsigned total, idx;
            result_t     r;
            tw = eff_size(tgt_w, MAX_WIDTH);
            th = eff_size(tgt_h, MAX_HEIGHT);
            sw = eff_size(src_w, MAX_WIDTH);
            sh = eff_size(src_h, MAX_HEIGHT);
            // signed offsets, truncated toward zero
            sx = (tw - sw) / 2;
            sy = (th - sh) / 2;
            ex = (tw + sw) / 2;
            ey = (th + sh) / 2;
            total = tw * th;
            x = int'(col) + sx;
            y = int'(row) + sy;

            // kept pixel: gap run first if it lands past the next index
            if (x >= 0 && x < tw && x < ex && y >= 0 && y < th && y < ey) begin
                idx = y * tw + x;
                if (idx > next_idx) push_run(idx - next_idx, 1'b0);
                r.item_kind  = KIND_PIXEL;
                r.run_length = IDX_W'(1);
                r.out_red    = p.pixel_red;
                r.out_green  = p.pixel_green;
                r.out_blue   = p.pixel_blue;
                r.frame_end  = (idx + 1 == total);
                pending_results.push_back(r);
                next_idx = IDX_W'(idx + 1);
            end

            // advance position; tail run closes the frame
            if (int'(col) + 1 >= sw) begin
                col = '0;
                if (int'(row) + 1 >= sh) begin
                    if (total > next_idx) push_run(total - next_idx, 1'b1);
                    row = '0;
                    next_idx = '0;
                end else begin
                    row = row + COORD_W'(1);
                end
            end else begin
                col = col + COORD_W'(1);
            end
        endfunction

        function void check_field(string name, logic [IDX_W-1:0] exp_v,
                                  logic [IDX_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d len %0d",
                       got.item_kind, got.run_length);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("item_kind",  IDX_W'(want.item_kind), IDX_W'(got.item_kind));
            check_field("run_length", want.run_length,        got.run_length);
            check_field("out_red",    IDX_W'(want.out_red),   IDX_W'(got.out_red));
            check_field("out_green",  IDX_W'(want.out_green), IDX_W'(got.out_green));
            check_field("out_blue",   IDX_W'(want.out_blue),  IDX_W'(got.out_blue));
            check_field("frame_end",  IDX_W'(want.frame_end), IDX_W'(got.frame_end));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

    endclass

endpackage

// File: tb/sv/tb_center_pad_crop_image.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_center_pad_crop_image: testbench for the center pad/crop block
// Directed frames for padding, cropping, clamped sizes and a size change in
// the middle of a frame, then random frames under random sizes and colors.
// Both channels idle at random; every result is checked against a predictor.
// ----------------------------------------------------------------------------
module tb_center_pad_crop_image;

    import cpc_pkg::*;
    import cpc_sb_pkg::*;

    localparam int NUM_REGS     = 7;
    localparam int RANDOM_ITEMS = 155;
    localparam int DRAIN_CYCLES = 16;    // front stages plus queue, with margin
    localparam int STALL_LIMIT  = 1000;  // cycles without any accepted request

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [SIZE_W-1:0]     cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_t                s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    result_t               m_data;

    pad_crop_scoreboard sb = new();

    logic [SIZE_W-1:0] cfg_vals [NUM_REGS];
    logic              steady      = 1'b0;   // no idling on either side
    int                quiet_cycles = 0;
    int                rand_sent   = 0;

    center_pad_crop_image u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 16);
        end
    end

    // check results, note accepted requests, count quiet cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_source_pixel(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // valid stays high between back-to-back requests
    task automatic send_pixel(input pixel_t p);
        if (!steady && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_pixel(pixel_t'(24'($urandom)));
    endtask

    // wait out every pending result and the cropped pixels still in flight;
    // wait for the clock edge first so the last accepted pixel has been noted
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config();
        cfg_reg_t r;
        for (int i = 0; i < NUM_REGS; i++) begin
            r = cfg_reg_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= r;
            cfg_wdata <= cfg_vals[i];
            @(posedge aclk);
            sb.set_reg(r, cfg_vals[i]);
        end
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [SIZE_W-1:0] tw, th, sw, sh,
                                input logic [SIZE_W-1:0] red, green, blue);
        cfg_vals[REG_TARGET_WIDTH]  = tw;
        cfg_vals[REG_TARGET_HEIGHT] = th;
        cfg_vals[REG_SOURCE_WIDTH]  = sw;
        cfg_vals[REG_SOURCE_HEIGHT] = sh;
        cfg_vals[REG_BG_RED]        = red;
        cfg_vals[REG_BG_GREEN]      = green;
        cfg_vals[REG_BG_BLUE]       = blue;
        write_config();
    endtask

    // mostly small sizes, some zero, maximum and oversize values
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 9) return SIZE_W'(MAX_WIDTH);
        if (r < 12) return SIZE_W'($urandom_range(8191, MAX_WIDTH + 1));
        return SIZE_W'($urandom_range(8, 1));
    endfunction

    // timeout
    initial begin
        wait (aresetn);
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[center_pad_crop_image] ERROR");
        $finish;
    end

    initial begin
        int n, frame_px;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes: every pixel completes a one-pixel frame
        send_pixel('0);
        send_pixel('1);
        drain();

        // one pixel in a 3x3 frame: gap run, pixel, tail run
        set_geometry(3, 3, 1, 1, 255, 0, 170);
        send_pixel(pixel_t'(24'h55AA55));
        drain();

        // padding on both axes
        set_geometry(4, 3, 2, 1, 0, 255, 85);
        send_random(2);
        drain();

        // cropping with an odd width difference; frame completed by a pixel
        set_geometry(2, 1, 3, 3, 13'h1F00, 13'h1FFF, 0);
        send_random(9);
        drain();

        // zero sizes read as one, oversize width reads as the maximum
        set_geometry(13'h1FFF, 0, 0, 0, 0, 255, 0);
        send_pixel(pixel_t'(24'hFF00FF));
        drain();

        // largest frame, longest runs
        set_geometry(MAX_WIDTH, MAX_HEIGHT, 1, 1, 1, 2, 3);
        send_pixel(pixel_t'(24'h00FF00));
        drain();

        // target width shrinks in the middle of a frame
        set_geometry(3, 3, 3, 3, 9, 8, 7);
        send_random(4);
        drain();
        set_geometry(2, 3, 3, 3, 9, 8, 7);
        send_random(5);
        drain();

        // random phases, mostly whole frames
        while (rand_sent < RANDOM_ITEMS) begin
            set_geometry(pick_size(), pick_size(), pick_size(), pick_size(),
                         SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
            frame_px = sb.eff_size(cfg_vals[REG_SOURCE_WIDTH], MAX_WIDTH) *
                       sb.eff_size(cfg_vals[REG_SOURCE_HEIGHT], MAX_HEIGHT);
            if (frame_px > 64) begin
                n = $urandom_range(12, 1);
            end else if ($urandom_range(7) == 0) begin
                n = $urandom_range(frame_px, 1);    // broken frame
            end else begin
                n = frame_px * $urandom_range(2, 1);
            end
            // keep the total near the planned item count
            if (n > RANDOM_ITEMS - rand_sent) begin
                n = RANDOM_ITEMS - rand_sent;
            end
            for (int i = 0; i < n; i++) begin
                steady <= (rand_sent >= 60 && rand_sent < 110);
                send_pixel(pixel_t'(24'($urandom)));
                rand_sent++;
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[center_pad_crop_image] OK");
        end else begin
            $display("[center_pad_crop_image] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cpc_pkg.sv
rtl/cpc_cfg.sv
rtl/cpc_front.sv
rtl/cpc_queue.sv
rtl/cpc_back.sv
rtl/center_pad_crop_image.sv
rtl/cpc_checker.sv
tb/sv/cpc_sb_pkg.sv
tb/sv/tb_center_pad_crop_image.sv
